// File: rtl/php_pkg.sv
// Shared types and constants for the packet header parser.
package php_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [1:0]  network_kind;
    logic [1:0]  transport_kind;
    logic [15:0] frame_type;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] frame_length;
  } out_item_t;

  // Outcome codes
  localparam logic [2:0] OUT_OK         = 3'd0;
  localparam logic [2:0] OUT_SHORT_ETH  = 3'd1;
  localparam logic [2:0] OUT_SHORT_IPV6 = 3'd2;
  localparam logic [2:0] OUT_SHORT_IPV4 = 3'd3;
  localparam logic [2:0] OUT_SHORT_OPTS = 3'd4;
  localparam logic [2:0] OUT_SHORT_TCP  = 3'd5;
  localparam logic [2:0] OUT_SHORT_UDP  = 3'd6;
  localparam logic [2:0] OUT_UNKNOWN    = 3'd7;

  // Layer kinds
  localparam logic [1:0] NET_NONE   = 2'd0;
  localparam logic [1:0] NET_IPV4   = 2'd1;
  localparam logic [1:0] NET_IPV6   = 2'd2;
  localparam logic [1:0] TRANS_NONE = 2'd0;
  localparam logic [1:0] TRANS_TCP  = 2'd1;
  localparam logic [1:0] TRANS_UDP  = 2'd2;

  // Frame layout
  localparam logic [15:0] ETH_LEN      = 16'd14;
  localparam logic [15:0] IPV6_END     = 16'd54;
  localparam logic [15:0] IPV4_MIN_END = 16'd34;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [15:0] TYPE_IPV6    = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [15:0] TCP_LEN      = 16'd20;
  localparam logic [15:0] UDP_LEN      = 16'd8;

endpackage

// File: rtl/packet_header_parser.sv
// Packet header parser top level: byte-stream Ethernet/IP/TCP/UDP header decode.
//
// Usage
//   in_*  : one frame byte per transfer, in wire order; last_byte marks the
//           final byte of the frame. Every byte may follow in the next cycle.
//   out_* : one result per frame, carrying outcome, layer kinds, ethertype,
//           addresses, ports and the (saturating) frame length.
// Timing
//   Throughput is one byte per cycle while no last byte waits on a stalled
//   receiver. A byte is held in an input register, then one pass of
//   position-indexed capture and decode logic updates the frame state and,
//   on the last byte, loads the result register, which drives out_valid.
// Reset and stalls
//   rst_n (synchronous, active low) clears the frame state and both valid
//   flags. Bytes that are not last never wait on the result side; while a
//   result is held by a stalled receiver, a last byte waits in the input
//   register and in_ready drops only then.
// Frames of MAX_FRAME_BYTES-1 bytes or more are judged at that length.
module packet_header_parser #(
  parameter int MAX_FRAME_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  php_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output php_pkg::out_item_t out_data
);

  localparam int          PW      = $clog2(MAX_FRAME_BYTES);
  localparam logic [15:0] LEN_CAP = 16'(MAX_FRAME_BYTES - 1);

  // Input register
  logic              s1_valid_r;
  php_pkg::in_item_t s1_item_r;
  logic              advance;

  // Frame state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   type_r, type_nxt;
  logic [3:0]    ihl_r, ihl_nxt;
  logic [7:0]    proto_r, proto_nxt;
  logic [63:0]   src_hi_r, src_hi_nxt, src_lo_r, src_lo_nxt;
  logic [63:0]   dst_hi_r, dst_hi_nxt, dst_lo_r, dst_lo_nxt;
  logic [31:0]   ports_r, ports_nxt;

  // Result register
  logic               out_valid_r;
  php_pkg::out_item_t out_r, res;

  logic [7:0]  b;
  logic [15:0] p;
  logic        in_range, is_v4, is_v6;
  logic [15:0] t_off, len, off;
  logic        addr_ok;

  // A non-last byte produces no result, so it always moves on.
  assign advance  = !s1_item_r.last_byte || !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  assign b        = s1_item_r.data_byte;
  assign p        = 16'(pos_r);
  assign in_range = (p >= php_pkg::ETH_LEN) && (p < LEN_CAP);
  assign is_v4    = (type_r == php_pkg::TYPE_IPV4);
  assign is_v6    = (type_r == php_pkg::TYPE_IPV6);

  // Captures at fixed byte positions, plus the port bytes that follow the network header.
  always_comb begin
    type_nxt   = type_r;
    ihl_nxt    = ihl_r;
    proto_nxt  = proto_r;
    src_hi_nxt = src_hi_r;
    src_lo_nxt = src_lo_r;
    dst_hi_nxt = dst_hi_r;
    dst_lo_nxt = dst_lo_r;
    ports_nxt  = ports_r;
    t_off      = 16'd0;

    if (p == 16'd12) begin
      type_nxt = {b, type_r[7:0]};
    end else if (p == 16'd13) begin
      type_nxt = {type_r[15:8], b};
    end

    if (in_range && is_v4) begin
      if (p == 16'd14) ihl_nxt = b[3:0];
      if (p == 16'd23) proto_nxt = b;
      if (p >= 16'd26 && p <= 16'd29) src_lo_nxt = {32'd0, src_lo_r[23:0], b};
      if (p >= 16'd30 && p <= 16'd33) dst_lo_nxt = {32'd0, dst_lo_r[23:0], b};
      // The IHL byte itself may fall inside the port window when IHL is zero.
      t_off = php_pkg::ETH_LEN + {10'd0, ihl_nxt, 2'b00};
    end else if (in_range && is_v6) begin
      if (p == 16'd20) proto_nxt = b;
      if (p >= 16'd22 && p <= 16'd29) src_hi_nxt = {src_hi_r[55:0], b};
      if (p >= 16'd30 && p <= 16'd37) src_lo_nxt = {src_lo_r[55:0], b};
      if (p >= 16'd38 && p <= 16'd45) dst_hi_nxt = {dst_hi_r[55:0], b};
      if (p >= 16'd46 && p <= 16'd53) dst_lo_nxt = {dst_lo_r[55:0], b};
      t_off = php_pkg::IPV6_END;
    end

    if (in_range && (is_v4 || is_v6) && p >= t_off && p <= t_off + 16'd3) begin
      ports_nxt = {ports_r[23:0], b};
    end

    pos_nxt = (p < LEN_CAP) ? pos_r + 1'b1 : pos_r;
  end

  // Frame verdict, built from the state including this byte.
  always_comb begin
    res     = '0;
    addr_ok = 1'b0;
    off     = 16'd0;
    len     = (p < LEN_CAP) ? p + 16'd1 : LEN_CAP;
    res.frame_length = len;

    if (len < php_pkg::ETH_LEN) begin
      res.outcome = php_pkg::OUT_SHORT_ETH;
    end else begin
      res.frame_type = type_nxt;
      if (type_nxt == php_pkg::TYPE_IPV6) begin
        if (len < php_pkg::IPV6_END) begin
          res.outcome = php_pkg::OUT_SHORT_IPV6;
        end else begin
          res.network_kind = php_pkg::NET_IPV6;
          addr_ok          = 1'b1;
          off              = php_pkg::IPV6_END;
          res.source_high  = src_hi_nxt;
          res.source_low   = src_lo_nxt;
          res.dest_high    = dst_hi_nxt;
          res.dest_low     = dst_lo_nxt;
        end
      end else if (type_nxt == php_pkg::TYPE_IPV4) begin
        if (len < php_pkg::IPV4_MIN_END) begin
          res.outcome = php_pkg::OUT_SHORT_IPV4;
        end else begin
          res.network_kind = php_pkg::NET_IPV4;
          off = php_pkg::ETH_LEN + {10'd0, ihl_nxt, 2'b00};
          if (len < off) begin
            res.outcome = php_pkg::OUT_SHORT_OPTS;
          end else begin
            addr_ok        = 1'b1;
            res.source_low = {32'd0, src_lo_nxt[31:0]};
            res.dest_low   = {32'd0, dst_lo_nxt[31:0]};
          end
        end
      end else begin
        res.outcome = php_pkg::OUT_UNKNOWN;
      end

      if (addr_ok) begin
        if (proto_nxt == php_pkg::PROTO_TCP) begin
          if (len >= off + php_pkg::TCP_LEN) res.transport_kind = php_pkg::TRANS_TCP;
          else res.outcome = php_pkg::OUT_SHORT_TCP;
        end else if (proto_nxt == php_pkg::PROTO_UDP) begin
          if (len >= off + php_pkg::UDP_LEN) res.transport_kind = php_pkg::TRANS_UDP;
          else res.outcome = php_pkg::OUT_SHORT_UDP;
        end
        if (res.transport_kind != php_pkg::TRANS_NONE) begin
          res.source_port = ports_nxt[31:16];
          res.dest_port   = ports_nxt[15:0];
        end
      end
    end
  end

  // Input register: load on every input transfer, drop once consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // Frame state: advance on each processed byte, clear after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_valid_r && advance && s1_item_r.last_byte)) begin
      pos_r    <= '0;
      type_r   <= '0;
      ihl_r    <= '0;
      proto_r  <= '0;
      src_hi_r <= '0;
      src_lo_r <= '0;
      dst_hi_r <= '0;
      dst_lo_r <= '0;
      ports_r  <= '0;
    end else if (s1_valid_r && advance) begin
      pos_r    <= pos_nxt;
      type_r   <= type_nxt;
      ihl_r    <= ihl_nxt;
      proto_r  <= proto_nxt;
      src_hi_r <= src_hi_nxt;
      src_lo_r <= src_lo_nxt;
      dst_hi_r <= dst_hi_nxt;
      dst_lo_r <= dst_lo_nxt;
      ports_r  <= ports_nxt;
    end
  end

  // Result register: hold until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_item_r.last_byte && advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_valid_r && s1_item_r.last_byte && advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sim/tb_packet_header_parser.sv
// Self-checking testbench for packet_header_parser: directed and random frames against a byte-level predictor.
module tb_packet_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  // Keep in step with the parameter handed to the instance below.
  localparam int MAX_BYTES = 65536;
  localparam int unsigned FRAME_CAP = (MAX_BYTES - 1 > 65535) ? 65535 : MAX_BYTES - 1;

  // Fill patterns for the frame payload before headers are stamped in.
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  localparam int ITEM_COUNT = 1050;

  // Tracks the frame state byte by byte and holds the results still owed by the block.
  class frame_scoreboard;
    int unsigned        pos;
    logic [15:0]        ether_word;
    logic [3:0]         ihl_reg;
    logic [7:0]         proto_reg;
    logic [63:0]        src_hi, src_lo, dst_hi, dst_lo;
    logic [31:0]        ports;
    php_pkg::out_item_t expected_q[$];
    int                 errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos        = 0;
      ether_word = '0;
      ihl_reg    = '0;
      proto_reg  = '0;
      src_hi     = '0;
      src_lo     = '0;
      dst_hi     = '0;
      dst_lo     = '0;
      ports      = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the frame state by one accepted byte; queue a result on the last one.
    function void note_byte(php_pkg::in_item_t it);
      logic [7:0]         b;
      int unsigned        p, t, len, off;
      bit                 have_t, reached;
      php_pkg::out_item_t e;
      b       = it.data_byte;
      p       = pos;
      t       = 0;
      have_t  = 1'b0;
      reached = 1'b0;
      off     = 0;

      if (p == 12) ether_word[15:8] = b;
      else if (p == 13) ether_word[7:0] = b;

      if (p >= php_pkg::ETH_LEN && p < FRAME_CAP) begin
        if (ether_word == php_pkg::TYPE_IPV4) begin
          if (p == 14) ihl_reg = b[3:0];
          if (p == 23) proto_reg = b;
          if (p >= 26 && p <= 29) src_lo = {32'h0, src_lo[23:0], b};
          if (p >= 30 && p <= 33) dst_lo = {32'h0, dst_lo[23:0], b};
          t      = 32'(php_pkg::ETH_LEN) + 4 * ihl_reg;
          have_t = 1'b1;
        end else if (ether_word == php_pkg::TYPE_IPV6) begin
          if (p == 20) proto_reg = b;
          if (p >= 22 && p <= 29) src_hi = {src_hi[55:0], b};
          if (p >= 30 && p <= 37) src_lo = {src_lo[55:0], b};
          if (p >= 38 && p <= 45) dst_hi = {dst_hi[55:0], b};
          if (p >= 46 && p <= 53) dst_lo = {dst_lo[55:0], b};
          t      = 32'(php_pkg::IPV6_END);
          have_t = 1'b1;
        end
        if (have_t && p >= t && p <= t + 3) ports = {ports[23:0], b};
      end

      if (pos < FRAME_CAP) pos++;
      if (!it.last_byte) return;

      len = (p < FRAME_CAP) ? p + 1 : FRAME_CAP;
      e = '0;
      e.frame_length = len[15:0];
      if (len < php_pkg::ETH_LEN) begin
        e.outcome = php_pkg::OUT_SHORT_ETH;
      end else begin
        e.frame_type = ether_word;
        if (ether_word == php_pkg::TYPE_IPV6) begin
          if (len < php_pkg::IPV6_END) begin
            e.outcome = php_pkg::OUT_SHORT_IPV6;
          end else begin
            e.network_kind = php_pkg::NET_IPV6;
            reached        = 1'b1;
            off            = 32'(php_pkg::IPV6_END);
            e.source_high  = src_hi;
            e.source_low   = src_lo;
            e.dest_high    = dst_hi;
            e.dest_low     = dst_lo;
          end
        end else if (ether_word == php_pkg::TYPE_IPV4) begin
          if (len < php_pkg::IPV4_MIN_END) begin
            e.outcome = php_pkg::OUT_SHORT_IPV4;
          end else begin
            e.network_kind = php_pkg::NET_IPV4;
            off = 32'(php_pkg::ETH_LEN) + 4 * ihl_reg;
            if (len < off) begin
              e.outcome = php_pkg::OUT_SHORT_OPTS;
            end else begin
              reached      = 1'b1;
              e.source_low = {32'h0, src_lo[31:0]};
              e.dest_low   = {32'h0, dst_lo[31:0]};
            end
          end
        end else begin
          e.outcome = php_pkg::OUT_UNKNOWN;
        end
        if (reached) begin
          if (proto_reg == php_pkg::PROTO_TCP) begin
            if (len >= off + php_pkg::TCP_LEN) e.transport_kind = php_pkg::TRANS_TCP;
            else e.outcome = php_pkg::OUT_SHORT_TCP;
          end else if (proto_reg == php_pkg::PROTO_UDP) begin
            if (len >= off + php_pkg::UDP_LEN) e.transport_kind = php_pkg::TRANS_UDP;
            else e.outcome = php_pkg::OUT_SHORT_UDP;
          end
          if (e.transport_kind != php_pkg::TRANS_NONE) begin
            e.source_port = ports[31:16];
            e.dest_port   = ports[15:0];
          end
        end
      end
      expected_q = {expected_q, e};
      clear_frame();
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Compare one accepted result against the oldest owed one.
    function void check_result(php_pkg::out_item_t got);
      php_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare_field("outcome",        64'(e.outcome),        64'(got.outcome));
      compare_field("network_kind",   64'(e.network_kind),   64'(got.network_kind));
      compare_field("transport_kind", 64'(e.transport_kind), 64'(got.transport_kind));
      compare_field("frame_type",     64'(e.frame_type),     64'(got.frame_type));
      compare_field("source_high",    e.source_high,         got.source_high);
      compare_field("source_low",     e.source_low,          got.source_low);
      compare_field("dest_high",      e.dest_high,           got.dest_high);
      compare_field("dest_low",       e.dest_low,            got.dest_low);
      compare_field("source_port",    64'(e.source_port),    64'(got.source_port));
      compare_field("dest_port",      64'(e.dest_port),      64'(got.dest_port));
      compare_field("frame_length",   64'(e.frame_length),   64'(got.frame_length));
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  php_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  php_pkg::out_item_t out_data;

  frame_scoreboard sb;
  logic [7:0] frame_q[$];
  int         bytes_sent = 0;
  int         frames_sent = 0;
  bit         no_idle = 1'b0;   // set to run stretches without any gaps on either side
  int         rx_hold = 0;

  packet_header_parser #(
    .MAX_FRAME_BYTES(MAX_BYTES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Result side: check every transfer, then decide whether to stall the next cycle.
  // Outputs are sampled at the edge, before the block's registers move.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      rx_hold = pick_gap();
      out_ready <= (rx_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hold one byte on the input until its transfer, then note it in the predictor.
  task automatic send_byte(php_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(it);
    bytes_sent++;
  endtask

  // Stream frame_q as one frame; drop valid for a random gap after a transfer.
  task automatic send_frame();
    php_pkg::in_item_t it;
    int                gap;
    for (int i = 0; i < frame_q.size(); i++) begin
      it.data_byte = frame_q[i];
      it.last_byte = (i == frame_q.size() - 1);
      send_byte(it);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    frames_sent++;
  endtask

  // Fill a frame, stamp ethertype, IHL and protocol where the frame is long enough, send it.
  task automatic send_ip(logic [15:0] etype, logic [3:0] ihl, logic [7:0] proto,
                         int len, int fill);
    logic [7:0] fb;
    frame_q.delete();
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: fb = 8'h00;
        FILL_ONES: fb = 8'hFF;
        default:   fb = 8'($urandom);
      endcase
      frame_q = {frame_q, fb};
    end
    if (len > 12) frame_q[12] = etype[15:8];
    if (len > 13) frame_q[13] = etype[7:0];
    if (etype == php_pkg::TYPE_IPV4) begin
      if (len > 14) frame_q[14] = {4'($urandom), ihl};
      if (len > 23) frame_q[23] = proto;
    end else if (etype == php_pkg::TYPE_IPV6) begin
      if (len > 20) frame_q[20] = proto;
    end
    send_frame();
  endtask

  // Hold the sender until the block owes nothing.
  task automatic wait_drained();
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Pick a length around the threshold that matters, sometimes anywhere up to thirty bytes past it.
  function automatic int pick_len(int need);
    int len;
    if ($urandom_range(0, 9) < 8) len = need - 3 + $urandom_range(0, 6);
    else len = $urandom_range(1, need + 30);
    return (len < 1) ? 1 : len;
  endfunction

  function automatic logic [7:0] pick_proto();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return php_pkg::PROTO_TCP;
    if (r < 8) return php_pkg::PROTO_UDP;
    return 8'($urandom);
  endfunction

  function automatic int transport_need(logic [7:0] proto);
    if (proto == php_pkg::PROTO_TCP) return int'(php_pkg::TCP_LEN);
    if (proto == php_pkg::PROTO_UDP) return int'(php_pkg::UDP_LEN);
    return 0;
  endfunction

  initial begin
    int          r, need, hdr;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames: most length thresholds on both sides, both IP versions,
    // TCP, UDP and other protocols, odd IHL values, unknown ethertypes.
    send_ip(16'h0000,           4'd0,  8'h00,              1,  FILL_ONES);   // single byte
    send_ip(php_pkg::TYPE_IPV4, 4'd5,  php_pkg::PROTO_TCP, 13, FILL_ZERO);   // one short of eth
    send_ip(php_pkg::TYPE_IPV6, 4'd0,  php_pkg::PROTO_TCP, 14, FILL_RANDOM);
    send_ip(php_pkg::TYPE_IPV6, 4'd0,  php_pkg::PROTO_TCP, 53, FILL_RANDOM);
    send_ip(php_pkg::TYPE_IPV6, 4'd0,  php_pkg::PROTO_TCP, 54, FILL_RANDOM);
    send_ip(php_pkg::TYPE_IPV6, 4'd0,  php_pkg::PROTO_TCP, 74, FILL_RANDOM);
    send_ip(php_pkg::TYPE_IPV6, 4'd0,  php_pkg::PROTO_UDP, 61, FILL_RANDOM);
    send_ip(php_pkg::TYPE_IPV6, 4'd0,  php_pkg::PROTO_UDP, 62, FILL_ONES);
    send_ip(php_pkg::TYPE_IPV6, 4'd0,  8'h3A,              54, FILL_RANDOM); // other next header
    send_ip(php_pkg::TYPE_IPV4, 4'd5,  php_pkg::PROTO_TCP, 33, FILL_RANDOM);
    send_ip(php_pkg::TYPE_IPV4, 4'd5,  php_pkg::PROTO_TCP, 53, FILL_RANDOM);
    send_ip(php_pkg::TYPE_IPV4, 4'd5,  php_pkg::PROTO_TCP, 54, FILL_ONES);
    send_ip(php_pkg::TYPE_IPV4, 4'd5,  php_pkg::PROTO_UDP, 41, FILL_RANDOM);
    send_ip(php_pkg::TYPE_IPV4, 4'd5,  php_pkg::PROTO_UDP, 42, FILL_ZERO);
    send_ip(php_pkg::TYPE_IPV4, 4'd15, php_pkg::PROTO_UDP, 73, FILL_RANDOM); // options cut short
    send_ip(php_pkg::TYPE_IPV4, 4'd15, php_pkg::PROTO_UDP, 82, FILL_RANDOM);
    send_ip(php_pkg::TYPE_IPV4, 4'd15, 8'h01,              74, FILL_RANDOM); // other protocol
    send_ip(php_pkg::TYPE_IPV4, 4'd0,  php_pkg::PROTO_UDP, 34, FILL_RANDOM); // ports on IHL byte
    send_ip(php_pkg::TYPE_IPV4, 4'd3,  php_pkg::PROTO_TCP, 46, FILL_RANDOM); // IHL below five
    send_ip(16'hFFFF,           4'd0,  8'h00,              20, FILL_ONES);
    send_ip(16'h0000,           4'd0,  8'h00,              14, FILL_ZERO);

    // Let everything owed come back before the random part starts.
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    // Random frames: mostly well-formed headers with lengths near each threshold,
    // the rest short frames, unknown ethertypes and pure noise.
    frames_sent = 0;
    while (bytes_sent < ITEM_COUNT) begin
      if (frames_sent % 10 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) begin
        in_valid <= 1'b0;
        wait_drained();
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        r = $urandom_range(0, 9);
        if (r < 5) ihl = 4'd5;
        else if (r < 8) ihl = 4'($urandom_range(6, 15));
        else ihl = 4'($urandom_range(0, 4));
        proto = pick_proto();
        hdr   = int'(php_pkg::ETH_LEN) + 4 * ihl;
        need  = ((hdr > int'(php_pkg::IPV4_MIN_END)) ? hdr : int'(php_pkg::IPV4_MIN_END))
                + transport_need(proto);
        send_ip(php_pkg::TYPE_IPV4, ihl, proto, pick_len(need), FILL_RANDOM);
      end else if (r < 75) begin
        proto = pick_proto();
        send_ip(php_pkg::TYPE_IPV6, 4'd0, proto,
                pick_len(int'(php_pkg::IPV6_END) + transport_need(proto)), FILL_RANDOM);
      end else if (r < 85) begin
        send_ip(16'($urandom), 4'd0, 8'h00, $urandom_range(14, 80), FILL_RANDOM);
      end else if (r < 93) begin
        send_ip(16'($urandom), 4'd0, 8'h00, $urandom_range(1, 13), FILL_RANDOM);
      end else begin
        frame_q.delete();
        repeat ($urandom_range(1, 80)) frame_q = {frame_q, 8'($urandom)};
        send_frame();
      end
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then wait so that any stray result can still show.
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[packet_header_parser] OK");
    end else begin
      $display("[packet_header_parser] ERROR");
    end
    $finish;
  end

  // Hard stop for a hung handshake.
  initial begin
    #20_000_000;
    $display("[packet_header_parser] ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/php_pkg.sv
rtl/packet_header_parser.sv
sim/tb_packet_header_parser.sv
